>>> hw/rtl/bilinear_image_shift_macros.svh
// ----------------------------------------------------------------------------
// bilinear_image_shift_macros
// Assertion macros used by the bilinear image shift module.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_IMAGE_SHIFT_MACROS_SVH
`define BILINEAR_IMAGE_SHIFT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define BIS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define BIS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/bis_pkg.sv
// ----------------------------------------------------------------------------
// bis_pkg
// Constants and codes for the bilinear image shift block.
// ----------------------------------------------------------------------------
`default_nettype none

package bis_pkg;

	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int DEF_FRAC_BITS  = 8;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y      = 2'd3;

	localparam logic [8:0] RST_IMAGE_WIDTH  = 9'd256;
	localparam logic [8:0] RST_IMAGE_HEIGHT = 9'd256;

	localparam logic MODE_LOAD    = 1'b0;
	localparam logic MODE_COMPUTE = 1'b1;

	localparam int PIX_W     = 8;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 8;

endpackage

`default_nettype wire

>>> hw/rtl/bilinear_image_shift.sv
// ----------------------------------------------------------------------------
// bilinear_image_shift
// Frame store with bilinear sub-pixel translation of grey pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser is the mode (load or compute), tdata holds col, row
//   and pixel_in. A load word writes one pixel of the frame store and gives
//   no result; a compute word gives one word on the master stream holding
//   the blended pixel (0 when the source falls outside the frame).
//   Config port: write image_width, image_height, shift_x, shift_y (Q.8)
//   while the block is idle.
//   Throughput: loads are taken back to back, one per cycle, while no compute
//   is in progress. A compute runs from accept to the result register in steps:
//   it forms the source position, does four reads of the frame store, takes the
//   last read data, passes two multiply stages and loads the result. The next
//   word is taken in the cycle after the result is loaded; a source outside the
//   frame skips the reads and the multiply stages.
//   Reset: registers return to 256 x 256 and zero shift; the frame store is
//   not cleared and must be loaded before it is read.
//   Stall: a held result stalls the next compute only at its final step; no
//   word, load or compute, is taken while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bilinear_image_shift_macros.svh"

module bilinear_image_shift #(
	parameter int MAX_WIDTH  = bis_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bis_pkg::DEF_MAX_HEIGHT,
	parameter int FRAC_BITS  = bis_pkg::DEF_FRAC_BITS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [bis_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [bis_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [bis_pkg::S_TDATA_W-1:0]   s_tdata,  // col[7:0], row[15:8], pixel_in[23:16]
	input  wire logic                            s_tuser,  // mode
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [bis_pkg::M_TDATA_W-1:0]        m_tdata   // pixel_out[7:0]
);

	localparam int PW    = ((8 + FRAC_BITS) > 17 ? (8 + FRAC_BITS) : 17) + 2;
	localparam int XW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW    = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int GW    = FRAC_BITS + 1;
	localparam int HW    = 8 + FRAC_BITS;
	localparam int SW    = 8 + 2 * FRAC_BITS;
	localparam int LW    = 13;
	localparam int unsigned S_ONE = 1 << FRAC_BITS;
	localparam logic [SW-1:0] HALF = SW'(1) << (2 * FRAC_BITS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POS,
		ST_RD,
		ST_LAST,
		ST_MUL1,
		ST_MUL2,
		ST_OUT
	} state_t;

	state_t state_q;

	logic [8:0]         width_q;
	logic [8:0]         height_q;
	logic signed [16:0] shift_x_q;
	logic signed [16:0] shift_y_q;

	logic [7:0] col_s1;
	logic [7:0] row_s1;

	logic [XW-1:0]        x0_q;
	logic [YW-1:0]        y0_q;
	logic [FRAC_BITS-1:0] fx_q;
	logic [FRAC_BITS-1:0] fy_q;
	logic [1:0]           rd_cnt_q;
	logic                 rd_en_s1;
	logic [1:0]           rd_idx_s1;
	logic [7:0]           rd_data_q;
	logic [7:0]           pix_q [4];
	logic [HW-1:0]        h0_q;
	logic [HW-1:0]        h1_q;
	logic [SW-1:0]        sum_q;
	logic                 m_tvalid_q;
	logic [7:0]           m_tdata_q;

	logic [7:0] mem [DEPTH];

	logic                 accept;
	logic                 ld_ok;
	logic [AW-1:0]        ld_addr;
	logic [AW-1:0]        rd_addr;
	logic signed [PW-1:0] pos_x;
	logic signed [PW-1:0] pos_y;
	logic [LW-1:0]        w_eff;
	logic [LW-1:0]        h_eff;
	logic                 in_frame;
	logic [GW-1:0]        gx;
	logic [GW-1:0]        gy;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= bis_pkg::RST_IMAGE_WIDTH;
			height_q  <= bis_pkg::RST_IMAGE_HEIGHT;
			shift_x_q <= '0;
			shift_y_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				bis_pkg::REG_IMAGE_WIDTH:  width_q   <= cfg_data[8:0];
				bis_pkg::REG_IMAGE_HEIGHT: height_q  <= cfg_data[8:0];
				bis_pkg::REG_SHIFT_X:      shift_x_q <= $signed(cfg_data);
				bis_pkg::REG_SHIFT_Y:      shift_y_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// load address
	assign ld_ok = (32'(s_tdata[7:0]) < 32'(MAX_WIDTH)) && (32'(s_tdata[15:8]) < 32'(MAX_HEIGHT));
	assign ld_addr = AW'(32'(s_tdata[15:8]) * 32'(MAX_WIDTH) + 32'(s_tdata[7:0]));

	// source position, floor and fraction
	assign pos_x = $signed(PW'({col_s1, {FRAC_BITS{1'b0}}})) - PW'(shift_x_q);
	assign pos_y = $signed(PW'({row_s1, {FRAC_BITS{1'b0}}})) - PW'(shift_y_q);
	assign w_eff = (LW'(width_q) < LW'(MAX_WIDTH)) ? LW'(width_q) : LW'(MAX_WIDTH);
	assign h_eff = (LW'(height_q) < LW'(MAX_HEIGHT)) ? LW'(height_q) : LW'(MAX_HEIGHT);
	assign in_frame = !pos_x[PW-1] && !pos_y[PW-1]
		&& (32'(pos_x[PW-2:FRAC_BITS]) + 32'd2 <= 32'(w_eff))
		&& (32'(pos_y[PW-2:FRAC_BITS]) + 32'd2 <= 32'(h_eff));

	// neighbor order: bit0 = next column, bit1 = next row
	assign rd_addr = AW'((32'(y0_q) + 32'(rd_cnt_q[1])) * 32'(MAX_WIDTH)
		+ 32'(x0_q) + 32'(rd_cnt_q[0]));

	assign gx = GW'(S_ONE) - GW'(fx_q);
	assign gy = GW'(S_ONE) - GW'(fy_q);

	// frame store
	always_ff @(posedge clk) begin
		if (accept && s_tuser == bis_pkg::MODE_LOAD && ld_ok) begin
			mem[ld_addr] <= s_tdata[23:16];
		end
		if (state_q == ST_RD) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// read sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q  <= '0;
			rd_en_s1  <= 1'b0;
			rd_idx_s1 <= '0;
		end else begin
			rd_en_s1  <= (state_q == ST_RD);
			rd_idx_s1 <= rd_cnt_q;
			if (state_q == ST_RD) begin
				rd_cnt_q <= rd_cnt_q + 2'd1;
			end else begin
				rd_cnt_q <= '0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1 <= s_tdata[7:0];
			row_s1 <= s_tdata[15:8];
		end
		if (rd_en_s1) begin
			pix_q[rd_idx_s1] <= rd_data_q;
		end
		case (state_q)
			ST_POS: begin
				x0_q  <= XW'(pos_x[PW-1:FRAC_BITS]);
				y0_q  <= YW'(pos_y[PW-1:FRAC_BITS]);
				fx_q  <= pos_x[FRAC_BITS-1:0];
				fy_q  <= pos_y[FRAC_BITS-1:0];
				sum_q <= '0;
			end
			ST_MUL1: begin
				h0_q <= HW'(pix_q[0]) * HW'(gx) + HW'(pix_q[1]) * HW'(fx_q);
				h1_q <= HW'(pix_q[2]) * HW'(gx) + HW'(pix_q[3]) * HW'(fx_q);
			end
			ST_MUL2: begin
				sum_q <= SW'(h0_q) * SW'(gy) + SW'(h1_q) * SW'(fy_q) + HALF;
			end
			default: ;
		endcase
	end

	// control and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (m_tready && state_q != ST_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && s_tuser == bis_pkg::MODE_COMPUTE) begin
						state_q <= ST_POS;
					end
				end
				ST_POS: begin
					state_q <= in_frame ? ST_RD : ST_OUT;
				end
				ST_RD: begin
					if (rd_cnt_q == 2'd3) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_OUT;
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= sum_q[2*FRAC_BITS +: 8];
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`BIS_ASSERT_NXT(a_compute_starts, (accept && s_tuser == bis_pkg::MODE_COMPUTE), (state_q == ST_POS), "compute word did not start")
	`BIS_ASSERT_IMP(a_read_in_window, rd_en_s1, (state_q == ST_RD || state_q == ST_LAST), "read data outside read window")
	`BIS_ASSERT_NXT(a_outside_zero, (state_q == ST_POS && !in_frame), (state_q == ST_OUT && sum_q == '0), "outside source not zero")
	`BIS_ASSERT_IMP(a_result_from_out, $rose(m_tvalid_q), $past(state_q == ST_OUT), "result word without finish")

endmodule

`default_nettype wire
